[rtl/core/lcd_line_mode_timing_core_defines.svh]
// Assertion macros for the LCD line and mode timing core.
`ifndef LCD_LINE_MODE_TIMING_CORE_DEFINES_SVH
`define LCD_LINE_MODE_TIMING_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset.
`define LMT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define LMT_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LMT_ASSERT(name, prop, msg)
`define LMT_ASSERT_NEVER(name, cond, msg)

`endif

`endif

[rtl/core/lmt_pkg.sv]
// Constants and types for the LCD line and mode timing core.
package lmt_pkg;

    localparam int unsigned DOT_W   = 10;
    localparam int unsigned LINE_W  = 8;
    localparam int unsigned CYC_W   = 8;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [DOT_W-1:0] LINE_DOTS  = DOT_W'(456);
    localparam logic [DOT_W-1:0] OAM_START  = LINE_DOTS - DOT_W'(80);
    localparam logic [DOT_W-1:0] XFER_START = OAM_START - DOT_W'(172);

    localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = LINE_W'(144);
    localparam logic [LINE_W-1:0] LAST_LINE         = LINE_W'(154);

    typedef enum logic [MODE_W-1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_ENABLE     = 3'd0,
        CFG_LINE_COMPARE       = 3'd1,
        CFG_HBLANK_INT_ENABLE  = 3'd2,
        CFG_VBLANK_INT_ENABLE  = 3'd3,
        CFG_OAM_INT_ENABLE     = 3'd4,
        CFG_COINC_INT_ENABLE   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        lcd_mode_t         lcd_mode;
        logic [LINE_W-1:0] current_line;
        logic              coincidence;
        logic              status_interrupt;
        logic              vblank_interrupt;
        logic              draw_line_request;
        logic [LINE_W-1:0] draw_line_number;
    } lmt_result_t;

endpackage

[rtl/core/lcd_line_mode_timing_core.sv]
// LCD line and mode timing core: mode, line counter, coincidence and interrupts.

// Each input transfer carries the elapsed CPU time in elapsed_cycles and yields
// one result. The item is held in an input register; compare-and-add logic
// against the dot/line state produces the result register and the next
// state together, so one item is taken and one result produced every cycle
// when the output side is ready. The result register loads from the input
// register once any waiting result has been taken; only a low out_ready holds
// it back. The input register takes a new item while a result still waits,
// if it holds none itself. Configuration writes land at once; the user must
// make them only while the block is idle, as the block does not enforce it.
// With display_enable low every item clears mode, line, dot counter and
// coincidence and reports no interrupt or draw request.
`include "lcd_line_mode_timing_core_defines.svh"

module lcd_line_mode_timing_core
    import lmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CYC_W-1:0]      elapsed_cycles,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MODE_W-1:0]     lcd_mode,
    output logic [LINE_W-1:0]     current_line,
    output logic                  coincidence,
    output logic                  status_interrupt,
    output logic                  vblank_interrupt,
    output logic                  draw_line_request,
    output logic [LINE_W-1:0]     draw_line_number
);

    // configuration
    logic              display_enable_reg;
    logic [LINE_W-1:0] line_compare_reg;
    logic              hblank_int_enable_reg;
    logic              vblank_int_enable_reg;
    logic              oam_int_enable_reg;
    logic              coinc_int_enable_reg;

    // timing state
    logic [DOT_W-1:0]  dot_reg;
    logic [DOT_W-1:0]  dot_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    lcd_mode_t         mode_reg;
    lcd_mode_t         mode_next;
    logic              coinc_reg;
    logic              coinc_next;

    // pipeline
    logic              in_valid_reg;
    logic [CYC_W-1:0]  cycles_reg;
    logic              out_valid_reg;
    lmt_result_t       result_reg;
    lmt_result_t       result_next;
    logic              advance;

    logic [DOT_W-1:0]  dot_sum;
    logic              want_int;
    logic              line_done;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg    <= 1'b0;
            line_compare_reg      <= '0;
            hblank_int_enable_reg <= 1'b0;
            vblank_int_enable_reg <= 1'b0;
            oam_int_enable_reg    <= 1'b0;
            coinc_int_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_ENABLE:    display_enable_reg    <= cfg_data[0];
                CFG_LINE_COMPARE:      line_compare_reg      <= cfg_data[LINE_W-1:0];
                CFG_HBLANK_INT_ENABLE: hblank_int_enable_reg <= cfg_data[0];
                CFG_VBLANK_INT_ENABLE: vblank_int_enable_reg <= cfg_data[0];
                CFG_OAM_INT_ENABLE:    oam_int_enable_reg    <= cfg_data[0];
                CFG_COINC_INT_ENABLE:  coinc_int_enable_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        dot_next    = dot_reg;
        coinc_next  = coinc_reg;
        want_int    = 1'b0;
        line_done   = 1'b0;
        dot_sum     = dot_reg + DOT_W'(cycles_reg);
        result_next = '0;

        if (!display_enable_reg)
        begin
            mode_next  = MODE_HBLANK;
            line_next  = '0;
            dot_next   = '0;
            coinc_next = 1'b0;
        end
        else
        begin
            // pick the mode from the position before the cycles are added
            priority if (line_reg >= FIRST_VBLANK_LINE)
            begin
                mode_next = MODE_VBLANK;
                want_int  = vblank_int_enable_reg;
            end
            else if (dot_reg >= OAM_START)
            begin
                mode_next = MODE_OAM;
                want_int  = oam_int_enable_reg;
            end
            else if (dot_reg >= XFER_START)
            begin
                mode_next = MODE_XFER;
            end
            else
            begin
                mode_next = MODE_HBLANK;
                want_int  = hblank_int_enable_reg;
            end
            result_next.status_interrupt = want_int && (mode_next != mode_reg);

            line_done = (dot_sum >= LINE_DOTS);
            dot_next  = dot_sum;
            if (line_done)
            begin
                if (line_reg < FIRST_VBLANK_LINE)
                begin
                    result_next.draw_line_request = 1'b1;
                    result_next.draw_line_number  = line_reg;
                end
                result_next.vblank_interrupt = (line_reg == FIRST_VBLANK_LINE);
                line_next  = (line_reg == LAST_LINE) ? '0 : line_reg + LINE_W'(1);
                coinc_next = (line_next == line_compare_reg);
                if (coinc_next && coinc_int_enable_reg)
                begin
                    result_next.status_interrupt = 1'b1;
                end
                dot_next = dot_sum - LINE_DOTS;
            end
        end

        result_next.lcd_mode     = mode_next;
        result_next.current_line = line_next;
        result_next.coincidence  = coinc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dot_reg       <= '0;
            line_reg      <= '0;
            mode_reg      <= MODE_HBLANK;
            coinc_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                dot_reg       <= dot_next;
                line_reg      <= line_next;
                mode_reg      <= mode_next;
                coinc_reg     <= coinc_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold the item and the result, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cycles_reg <= elapsed_cycles;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign lcd_mode          = result_reg.lcd_mode;
    assign current_line      = result_reg.current_line;
    assign coincidence       = result_reg.coincidence;
    assign status_interrupt  = result_reg.status_interrupt;
    assign vblank_interrupt  = result_reg.vblank_interrupt;
    assign draw_line_request = result_reg.draw_line_request;
    assign draw_line_number  = result_reg.draw_line_number;

    `LMT_ASSERT_NEVER(a_line_range, line_reg > LAST_LINE, "line counter past last line")
    `LMT_ASSERT_NEVER(a_dot_range, dot_reg >= LINE_DOTS, "dot counter not wrapped")
    `LMT_ASSERT_NEVER(a_draw_vblank_excl,
        out_valid_reg && draw_line_request && vblank_interrupt,
        "draw request and vblank in one result")
    `LMT_ASSERT(a_draw_line_visible,
        (out_valid_reg && draw_line_request) |-> (draw_line_number < FIRST_VBLANK_LINE),
        "draw request for a line outside the visible area")

endmodule
